@@ rtl/dog_pkg.sv @@
// Shared types and constants for the DoG on/off convolution block.
// Used by dog_tap_seq, dog_mac and dog_on_off_convolution; depends on nothing.
`default_nettype none

package dog_pkg;

   // Request kinds carried in req_tuser.
   localparam logic [1:0] MODE_COEFF = 2'd0;
   localparam logic [1:0] MODE_PIXEL = 2'd1;
   localparam logic [1:0] MODE_CONV  = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] REG_KERNEL_SIZE   = 2'd0;
   localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd1;
   localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd2;
   localparam logic [1:0] REG_CHANNEL_COUNT = 2'd3;

   // Field widths of the stream words.
   localparam int POS_W   = 6;
   localparam int CHAN_W  = 2;
   localparam int KIDX_W  = 3;
   localparam int DATA_W  = 16;
   localparam int CSR_W   = 7;

   // Signed coordinate width used for tap positions and clamping.
   localparam int CRD_W   = 12;

   // Rounding of a Q1.30 magnitude to Q0.16.
   localparam int FRAC_SHIFT = 14;
   localparam int ROUND_BIAS = 8192;

   // One convolution job as handed to the tap sequencer.
   typedef struct packed {
      logic [2:0]        kernel_size;
      logic [6:0]        image_width;
      logic [6:0]        image_height;
      logic [POS_W-1:0]  pos_x;
      logic [POS_W-1:0]  pos_y;
      logic [CHAN_W-1:0] channel;
   } conv_job_type;

   // Control of the multiply-accumulate unit.
   typedef struct packed {
      logic clear;
      logic tap_valid;
      logic mag_load;
   } mac_ctl_type;

   // Status of the multiply-accumulate unit.
   typedef struct packed {
      logic busy;
   } mac_sts_type;

endpackage

`default_nettype wire

@@ rtl/dog_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
`default_nettype none

module dog_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write and read each take effect at the clock edge.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

@@ rtl/dog_tap_seq.sv @@
// Tap sequencer: walks the kernel rows and columns of one job and forms the
// clamped pixel and kernel read addresses. Depends on dog_pkg.
`default_nettype none

module dog_tap_seq
   import dog_pkg::*;
#(
   parameter int MAX_KERNEL   = 7,
   parameter int MAX_WIDTH    = 64,
   parameter int MAX_HEIGHT   = 64,
   parameter int MAX_CHANNELS = 4,
   parameter int KA_W         = 3,
   parameter int XA_W         = 6,
   parameter int YA_W         = 6,
   parameter int CA_W         = 2
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire conv_job_type                  job,
   output logic                               issue,
   output logic                               last,
   output logic [2*KA_W-1:0]                  kaddr,
   output logic [CA_W+YA_W+XA_W-1:0]          paddr
);

   localparam int KC_W = $clog2(MAX_KERNEL + 1);

   logic                    active_ff;
   logic [KC_W-1:0]         k_ff;
   logic [KC_W-1:0]         half_ff;
   logic [KC_W-1:0]         row_ff;
   logic [KC_W-1:0]         col_ff;
   logic signed [CRD_W-1:0] w_ff;
   logic signed [CRD_W-1:0] h_ff;
   logic [POS_W-1:0]        px_ff;
   logic [POS_W-1:0]        py_ff;
   logic [CRD_W-1:0]        ch_ff;

   logic [KC_W-1:0]         k_in;
   logic signed [CRD_W-1:0] w_in;
   logic signed [CRD_W-1:0] h_in;
   logic                    col_end;
   logic                    row_end;
   logic signed [CRD_W-1:0] x_raw;
   logic signed [CRD_W-1:0] y_raw;
   logic signed [CRD_W-1:0] x_cl;
   logic signed [CRD_W-1:0] y_cl;
   logic [CRD_W-1:0]        row_ext;
   logic [CRD_W-1:0]        col_ext;

   // Effective sizes: zero acts as one, oversize acts as the maximum.
   always_comb begin
      if (job.kernel_size == '0) begin
         k_in = KC_W'(1);
      end else if (int'(job.kernel_size) > MAX_KERNEL) begin
         k_in = KC_W'(MAX_KERNEL);
      end else begin
         k_in = KC_W'(job.kernel_size);
      end
      if (job.image_width == '0) begin
         w_in = CRD_W'(1);
      end else if (int'(job.image_width) > MAX_WIDTH) begin
         w_in = CRD_W'(MAX_WIDTH);
      end else begin
         w_in = CRD_W'(job.image_width);
      end
      if (job.image_height == '0) begin
         h_in = CRD_W'(1);
      end else if (int'(job.image_height) > MAX_HEIGHT) begin
         h_in = CRD_W'(MAX_HEIGHT);
      end else begin
         h_in = CRD_W'(job.image_height);
      end
   end

   assign col_end = (col_ff == KC_W'(k_ff - KC_W'(1)));
   assign row_end = (row_ff == KC_W'(k_ff - KC_W'(1)));

   // Row and column counters, one tap per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else if (start) begin
         active_ff <= 1'b1;
      end else if (active_ff && col_end && row_end) begin
         active_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         k_ff    <= k_in;
         half_ff <= k_in >> 1;
         w_ff    <= w_in;
         h_ff    <= h_in;
         px_ff   <= job.pos_x;
         py_ff   <= job.pos_y;
         ch_ff   <= CRD_W'(job.channel);
         row_ff  <= '0;
         col_ff  <= '0;
      end else if (active_ff) begin
         if (col_end) begin
            col_ff <= '0;
            row_ff <= KC_W'(row_ff + KC_W'(1));
         end else begin
            col_ff <= KC_W'(col_ff + KC_W'(1));
         end
      end
   end

   // Tap position relative to the anchor, clamped into the image.
   always_comb begin
      x_raw = signed'(CRD_W'(px_ff)) + signed'(CRD_W'(col_ff)) - signed'(CRD_W'(half_ff));
      y_raw = signed'(CRD_W'(py_ff)) + signed'(CRD_W'(row_ff)) - signed'(CRD_W'(half_ff));
      if (x_raw < 0) begin
         x_cl = '0;
      end else if (x_raw > w_ff - CRD_W'(1)) begin
         x_cl = w_ff - CRD_W'(1);
      end else begin
         x_cl = x_raw;
      end
      if (y_raw < 0) begin
         y_cl = '0;
      end else if (y_raw > h_ff - CRD_W'(1)) begin
         y_cl = h_ff - CRD_W'(1);
      end else begin
         y_cl = y_raw;
      end
   end

   assign row_ext = CRD_W'(row_ff);
   assign col_ext = CRD_W'(col_ff);

   assign issue = active_ff;
   assign last  = active_ff && col_end && row_end;
   assign kaddr = {row_ext[KA_W-1:0], col_ext[KA_W-1:0]};
   assign paddr = {ch_ff[CA_W-1:0], y_cl[YA_W-1:0], x_cl[XA_W-1:0]};

endmodule

`default_nettype wire

@@ rtl/dog_mac.sv @@
// Multiply-accumulate unit: one registered product per tap, a wide signed
// sum, then magnitude, rounding and saturation to Q0.16. Depends on dog_pkg.
`default_nettype none

module dog_mac
   import dog_pkg::*;
#(
   parameter int MAX_KERNEL = 7
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire mac_ctl_type       ctl,
   input  wire logic [DATA_W-1:0] pixel,
   input  wire logic [DATA_W-1:0] coeff,
   output mac_sts_type            sts,
   output logic [DATA_W-1:0]      on_value,
   output logic [DATA_W-1:0]      off_value
);

   localparam int PROD_W = 2 * DATA_W + 1;
   localparam int ACC_W  = PROD_W + $clog2(MAX_KERNEL * MAX_KERNEL) + 1;

   logic                     pv_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic [ACC_W-1:0]         mag_ff;
   logic                     pos_ff;
   logic                     neg_ff;

   logic signed [PROD_W-1:0] prod_in;
   logic [ACC_W:0]           rounded;
   logic [DATA_W-1:0]        sat;

   // Unsigned Q0.16 pixel times signed Q1.14 coefficient, both widened first.
   assign prod_in = PROD_W'($signed({1'b0, pixel})) * PROD_W'($signed(coeff));

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else begin
         pv_ff <= ctl.tap_valid;
      end
   end

   // Product stage, then the accumulator.
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (ctl.clear) begin
         acc_ff <= '0;
      end else if (pv_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
   end

   // Sign and magnitude of the finished sum.
   always_ff @(posedge clock) begin
      if (ctl.mag_load) begin
         pos_ff <= (acc_ff > 0);
         neg_ff <= (acc_ff < 0);
         mag_ff <= (acc_ff < 0) ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
      end
   end

   // Round to nearest with ties away from zero, then saturate.
   always_comb begin
      rounded = ((ACC_W + 1)'(mag_ff) + (ACC_W + 1)'(ROUND_BIAS)) >> FRAC_SHIFT;
      if (rounded > (ACC_W + 1)'({DATA_W{1'b1}})) begin
         sat = '1;
      end else begin
         sat = rounded[DATA_W-1:0];
      end
   end

   assign on_value  = pos_ff ? sat : '0;
   assign off_value = neg_ff ? sat : '0;
   assign sts.busy  = pv_ff;

endmodule

`default_nettype wire

@@ rtl/dog_on_off_convolution.sv @@
// Difference-of-Gaussians on/off convolution with pixel and kernel stores.
// Top level; depends on dog_pkg, dog_ram, dog_tap_seq and dog_mac.
//
// Usage: every request word on req_* carries a kind in req_tuser. A coefficient
// load or pixel load writes one store entry if its address is in range and
// answers with a word whose rsp_tuser is 0 and whose values are 0. A convolve
// request sums the kernel around (pos_x, pos_y) in one channel with replicated
// borders and answers with rsp_tuser 1 and the on and off values. Registers are
// to be written on csr_* only while no request is in flight; the block itself
// does not enforce this.
// A load goes from acceptance to the finish step and into the output register.
// A convolve walks the taps of the K by K kernel, K the effective kernel size,
// then the product stage, accumulator, rounding and the output word; the one
// read port of the pixel memory allows one tap a cycle. One request is
// processed at a time: a new one is taken only once the last has finished.
// Reset clears the control state and sets the registers to kernel size 5,
// 64 by 64 pixels and one channel; both stores hold nothing until loaded.
// When the receiver stalls, the finished word waits in the output register;
// the next request is still accepted and its result waits until that slot
// frees up.
`default_nettype none

module dog_on_off_convolution
   import dog_pkg::*;
#(
   parameter int MAX_KERNEL   = 7,
   parameter int MAX_WIDTH    = 64,
   parameter int MAX_HEIGHT   = 64,
   parameter int MAX_CHANNELS = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // Request stream.
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   // coeff_row[2:0], coeff_col[5:3], coeff_value[21:6], pixel_value[37:22],
   // pos_x[43:38], pos_y[49:44], channel[51:50], zero fill [55:52]
   input  wire logic [55:0]       req_tdata,
   // mode[1:0]
   input  wire logic [1:0]        req_tuser,
   // Response stream.
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   // on_value[15:0], off_value[31:16]
   output logic [31:0]            rsp_tdata,
   // has_result[0]
   output logic                   rsp_tuser,
   // Configuration write port.
   input  wire logic              csr_we,
   input  wire logic [1:0]        csr_index,
   input  wire logic [CSR_W-1:0]  csr_wdata
);

   localparam int KA_W = (MAX_KERNEL > 1)   ? $clog2(MAX_KERNEL)   : 1;
   localparam int XA_W = (MAX_WIDTH > 1)    ? $clog2(MAX_WIDTH)    : 1;
   localparam int YA_W = (MAX_HEIGHT > 1)   ? $clog2(MAX_HEIGHT)   : 1;
   localparam int CA_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int KDEPTH = 1 << (2 * KA_W);
   localparam int PA_W   = CA_W + YA_W + XA_W;
   localparam int PDEPTH = 1 << PA_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   state_type         state_ff;
   logic              rsp_valid_ff;
   logic              rsp_has_ff;
   logic [DATA_W-1:0] rsp_on_ff;
   logic [DATA_W-1:0] rsp_off_ff;
   logic              res_has_ff;
   logic              res_mac_ff;
   logic              rd_valid_ff;
   logic [2:0]        kernel_size_ff;
   logic [6:0]        image_width_ff;
   logic [6:0]        image_height_ff;
   logic [2:0]        channel_count_ff;

   // Request word fields.
   logic [1:0]        mode;
   logic [2:0]        coeff_row;
   logic [2:0]        coeff_col;
   logic [DATA_W-1:0] coeff_value;
   logic [DATA_W-1:0] pixel_value;
   logic [POS_W-1:0]  pos_x;
   logic [POS_W-1:0]  pos_y;
   logic [CHAN_W-1:0] channel;

   logic              accept;
   logic              ch_ok;
   logic              conv_start;
   logic              kwe;
   logic              pwe;
   logic [CRD_W-1:0]  crow_ext;
   logic [CRD_W-1:0]  ccol_ext;
   logic [CRD_W-1:0]  px_ext;
   logic [CRD_W-1:0]  py_ext;
   logic [CRD_W-1:0]  ch_ext;
   logic [2*KA_W-1:0] kwaddr;
   logic [PA_W-1:0]   pwaddr;
   conv_job_type      job;
   logic              seq_issue;
   logic              seq_last;
   logic [2*KA_W-1:0] kraddr;
   logic [PA_W-1:0]   praddr;
   logic [DATA_W-1:0] kdata;
   logic [DATA_W-1:0] pdata;
   mac_ctl_type       mac_ctl;
   mac_sts_type       mac_sts;
   logic [DATA_W-1:0] mac_on;
   logic [DATA_W-1:0] mac_off;
   logic              pipe_empty;

   assign mode        = req_tuser;
   assign coeff_row   = req_tdata[2:0];
   assign coeff_col   = req_tdata[5:3];
   assign coeff_value = req_tdata[21:6];
   assign pixel_value = req_tdata[37:22];
   assign pos_x       = req_tdata[43:38];
   assign pos_y       = req_tdata[49:44];
   assign channel     = req_tdata[51:50];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_size_ff   <= 3'd5;
         image_width_ff   <= 7'd64;
         image_height_ff  <= 7'd64;
         channel_count_ff <= 3'd1;
      end else if (csr_we) begin
         case (csr_index)
            REG_KERNEL_SIZE:   kernel_size_ff   <= csr_wdata[2:0];
            REG_IMAGE_WIDTH:   image_width_ff   <= csr_wdata;
            REG_IMAGE_HEIGHT:  image_height_ff  <= csr_wdata;
            REG_CHANNEL_COUNT: channel_count_ff <= csr_wdata[2:0];
            default: begin
            end
         endcase
      end
   end

   // Store write addresses and range checks for loads.
   assign crow_ext = CRD_W'(coeff_row);
   assign ccol_ext = CRD_W'(coeff_col);
   assign px_ext   = CRD_W'(pos_x);
   assign py_ext   = CRD_W'(pos_y);
   assign ch_ext   = CRD_W'(channel);
   assign kwaddr   = {crow_ext[KA_W-1:0], ccol_ext[KA_W-1:0]};
   assign pwaddr   = {ch_ext[CA_W-1:0], py_ext[YA_W-1:0], px_ext[XA_W-1:0]};

   assign kwe = accept && (mode == MODE_COEFF) &&
                (int'(coeff_row) < MAX_KERNEL) && (int'(coeff_col) < MAX_KERNEL);
   assign pwe = accept && (mode == MODE_PIXEL) && (int'(pos_x) < MAX_WIDTH) &&
                (int'(pos_y) < MAX_HEIGHT) && (int'(channel) < MAX_CHANNELS);

   // A channel at or beyond the effective count yields an all-zero result.
   assign ch_ok = (channel_count_ff == '0) ? (channel == '0) :
                  ((int'(channel) < int'(channel_count_ff)) &&
                   (int'(channel) < MAX_CHANNELS));
   assign conv_start = accept && (mode == MODE_CONV) && ch_ok;

   assign job.kernel_size  = kernel_size_ff;
   assign job.image_width  = image_width_ff;
   assign job.image_height = image_height_ff;
   assign job.pos_x        = pos_x;
   assign job.pos_y        = pos_y;
   assign job.channel      = channel;

   dog_ram #(
      .WIDTH (DATA_W),
      .DEPTH (KDEPTH)
   ) u_kernel_ram (
      .clock (clock),
      .we    (kwe),
      .waddr (kwaddr),
      .wdata (coeff_value),
      .raddr (kraddr),
      .rdata (kdata)
   );

   dog_ram #(
      .WIDTH (DATA_W),
      .DEPTH (PDEPTH)
   ) u_pixel_ram (
      .clock (clock),
      .we    (pwe),
      .waddr (pwaddr),
      .wdata (pixel_value),
      .raddr (praddr),
      .rdata (pdata)
   );

   dog_tap_seq #(
      .MAX_KERNEL   (MAX_KERNEL),
      .MAX_WIDTH    (MAX_WIDTH),
      .MAX_HEIGHT   (MAX_HEIGHT),
      .MAX_CHANNELS (MAX_CHANNELS),
      .KA_W         (KA_W),
      .XA_W         (XA_W),
      .YA_W         (YA_W),
      .CA_W         (CA_W)
   ) u_tap_seq (
      .clock (clock),
      .reset (reset),
      .start (conv_start),
      .job   (job),
      .issue (seq_issue),
      .last  (seq_last),
      .kaddr (kraddr),
      .paddr (praddr)
   );

   // Read data arrives in the cycle after the tap is issued.
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= seq_issue;
      end
   end

   assign pipe_empty        = !rd_valid_ff && !mac_sts.busy;
   assign mac_ctl.clear     = conv_start;
   assign mac_ctl.tap_valid = rd_valid_ff;
   assign mac_ctl.mag_load  = (state_ff == ST_DRAIN) && pipe_empty;

   dog_mac #(
      .MAX_KERNEL (MAX_KERNEL)
   ) u_mac (
      .clock     (clock),
      .reset     (reset),
      .ctl       (mac_ctl),
      .pixel     (pdata),
      .coeff     (kdata),
      .sts       (mac_sts),
      .on_value  (mac_on),
      .off_value (mac_off)
   );

   // Request sequencing and the output word register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         res_has_ff   <= 1'b0;
         res_mac_ff   <= 1'b0;
      end else begin
         // In the finish step the output register is refilled instead.
         if (rsp_valid_ff && rsp_tready && (state_ff != ST_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  res_has_ff <= (mode == MODE_CONV);
                  res_mac_ff <= conv_start;
                  state_ff   <= conv_start ? ST_RUN : ST_FINISH;
               end
            end
            ST_RUN: begin
               if (seq_last) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               if (pipe_empty) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_has_ff   <= res_has_ff;
                  rsp_on_ff    <= res_mac_ff ? mac_on : '0;
                  rsp_off_ff   <= res_mac_ff ? mac_off : '0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_has_ff;
   assign rsp_tdata  = {rsp_off_ff, rsp_on_ff};

endmodule

`default_nettype wire
